FILE: rtl/core/c6502_pkg.sv
package c6502_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_READ = 2'd1,
      CMD_EXEC = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IMM,
      MODE_ZP,
      MODE_ABS,
      MODE_ACC
   } mode_type;

   typedef enum logic [4:0] {
      K_LDA, K_STA, K_ADC, K_SBC, K_AND, K_ORA, K_EOR, K_BIT, K_INC, K_DEC,
      K_ASL, K_LSR, K_ROL, K_ROR, K_INX, K_INY, K_DEX, K_DEY, K_JMP, K_NONE
   } kind_type;

   typedef struct packed {
      mode_type mode;
      kind_type kind;
   } decode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OPC,
      ST_DEC,
      ST_OPLO,
      ST_OPHI,
      ST_JLO,
      ST_JHI,
      ST_OPER,
      ST_RDWAIT,
      ST_DONE
   } state_type;

   localparam logic [7:0] FLAG_C = 8'h01;
   localparam logic [7:0] FLAG_Z = 8'h02;
   localparam logic [7:0] FLAG_V = 8'h40;
   localparam logic [7:0] FLAG_N = 8'h80;

   function automatic decode_type decode_op(input logic [7:0] op);
      decode_type d;
      d.mode = MODE_ACC;
      d.kind = K_NONE;
      unique case (op)
         8'hA9: d = '{MODE_IMM, K_LDA};
         8'hA5: d = '{MODE_ZP,  K_LDA};
         8'hAD: d = '{MODE_ABS, K_LDA};
         8'h85: d = '{MODE_ZP,  K_STA};
         8'h8D: d = '{MODE_ABS, K_STA};
         8'h69: d = '{MODE_IMM, K_ADC};
         8'h65: d = '{MODE_ZP,  K_ADC};
         8'h6D: d = '{MODE_ABS, K_ADC};
         8'hE9: d = '{MODE_IMM, K_SBC};
         8'hE5: d = '{MODE_ZP,  K_SBC};
         8'hED: d = '{MODE_ABS, K_SBC};
         8'hE8: d = '{MODE_ACC, K_INX};
         8'hC8: d = '{MODE_ACC, K_INY};
         8'hCA: d = '{MODE_ACC, K_DEX};
         8'h88: d = '{MODE_ACC, K_DEY};
         8'hE6: d = '{MODE_ZP,  K_INC};
         8'hEE: d = '{MODE_ABS, K_INC};
         8'hC6: d = '{MODE_ZP,  K_DEC};
         8'hCE: d = '{MODE_ABS, K_DEC};
         8'h29: d = '{MODE_IMM, K_AND};
         8'h25: d = '{MODE_ZP,  K_AND};
         8'h2D: d = '{MODE_ABS, K_AND};
         8'h09: d = '{MODE_IMM, K_ORA};
         8'h05: d = '{MODE_ZP,  K_ORA};
         8'h0D: d = '{MODE_ABS, K_ORA};
         8'h49: d = '{MODE_IMM, K_EOR};
         8'h45: d = '{MODE_ZP,  K_EOR};
         8'h4D: d = '{MODE_ABS, K_EOR};
         8'h24: d = '{MODE_ZP,  K_BIT};
         8'h2C: d = '{MODE_ABS, K_BIT};
         8'h0A: d = '{MODE_ACC, K_ASL};
         8'h06: d = '{MODE_ZP,  K_ASL};
         8'h0E: d = '{MODE_ABS, K_ASL};
         8'h4A: d = '{MODE_ACC, K_LSR};
         8'h46: d = '{MODE_ZP,  K_LSR};
         8'h4E: d = '{MODE_ABS, K_LSR};
         8'h2A: d = '{MODE_ACC, K_ROL};
         8'h26: d = '{MODE_ZP,  K_ROL};
         8'h2E: d = '{MODE_ABS, K_ROL};
         8'h6A: d = '{MODE_ACC, K_ROR};
         8'h66: d = '{MODE_ZP,  K_ROR};
         8'h6E: d = '{MODE_ABS, K_ROR};
         8'h6C: d = '{MODE_ABS, K_JMP};
         default: d = '{MODE_ACC, K_NONE};
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/core/cpu6502_subset_core_unit.sv
// Subset 6502 core with its own byte memory.
// Input channel req_*: one transfer per command (load byte, read byte,
// execute one instruction at pc). req_tuser carries cmd.
// Result channel rsp_*: exactly one transfer per command, carrying the
// register file after the command plus read_byte, last_opcode, known_op.
// For a load or read the result is registered after the memory access; for
// execute the core reads the opcode, then the operand bytes, then the data
// (JMP indirect reads both pointer bytes), one access at a time through the
// single port of the byte memory; an unknown opcode ends after decode.
// The next command is taken the cycle after the result transfers.
// One command is in flight at a time; req_tready is high while no
// command is at work and the result register is free.
// Reset clears pc, A, X, Y and status to zero; memory is not cleared and
// must be loaded before it is read.
// When the receiver stalls, the result is held in the output register
// and no new command is taken until it transfers.
module cpu6502_subset_core_unit
   import c6502_pkg::*;
#(
   parameter int ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // cmd
   input  logic [23:0] req_tdata,  // mem_addr[15:0], mem_data[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // prog_counter, acc, index_x, index_y,
                                   // flags, read_byte, last_opcode, known_op,
                                   // zero pad
);

   state_type state_ff, state_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  acc_ff, acc_in, x_ff, x_in, y_ff, y_in, st_ff, st_in;
   logic [15:0] ea_ff, ea_in;
   logic [7:0]  op_ff, op_in, tmp_ff, tmp_in;
   cmd_type     cmd_ff, cmd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [64:0] rsp_data_ff, rsp_data_in;

   logic [ADDR_BITS-1:0] ram_addr;
   logic                 ram_we;
   logic [7:0]           ram_wd, ram_rd;
   decode_type           dec;
   logic [7:0]           a_o, x_o, y_o, s_o, wv;
   logic                 we_alu;
   logic [7:0]           alu_v;
   logic                 emit;
   logic [7:0]           emit_rd;
   logic                 emit_known;

   c6502_ram #(.WIDTH(8), .DEPTH(2 ** ADDR_BITS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   assign dec   = decode_op(op_ff);
   assign alu_v = (dec.mode == MODE_ACC) ? acc_ff : ram_rd;

   c6502_alu u_alu (
      .kind       (dec.kind),
      .acc_mode   (dec.mode == MODE_ACC),
      .v          (alu_v),
      .acc        (acc_ff),
      .idx_x      (x_ff),
      .idx_y      (y_ff),
      .status     (st_ff),
      .acc_out    (a_o),
      .x_out      (x_o),
      .y_out      (y_o),
      .status_out (s_o),
      .wr_val     (wv),
      .wr_en      (we_alu)
   );

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'h00, rsp_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         acc_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         st_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ea_ff       <= ea_in;
      op_ff       <= op_in;
      tmp_ff      <= tmp_in;
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      st_in        = st_ff;
      ea_in        = ea_ff;
      op_in        = op_ff;
      tmp_in       = tmp_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_addr     = pc_ff[ADDR_BITS-1:0];
      ram_we       = 1'b0;
      ram_wd       = req_tdata[23:16];
      emit         = 1'b0;
      emit_rd      = 8'h00;
      emit_known   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ram_addr = req_tdata[ADDR_BITS-1:0];
            if (req_tvalid && req_tready) begin
               cmd_in = cmd_type'(req_tuser);
               unique case (cmd_type'(req_tuser))
                  CMD_LOAD: begin ram_we = 1'b1; state_in = ST_DONE; end
                  CMD_READ: state_in = ST_RDWAIT;
                  CMD_EXEC: begin
                     ram_addr = pc_ff[ADDR_BITS-1:0];
                     pc_in    = pc_ff + 16'd1;
                     state_in = ST_OPC;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RDWAIT: begin
            emit    = 1'b1;
            emit_rd = ram_rd;
         end
         ST_DONE: emit = 1'b1;
         ST_OPC: begin
            op_in    = ram_rd;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            unique case (dec.mode)
               MODE_IMM: begin
                  ram_addr = pc_ff[ADDR_BITS-1:0];
                  pc_in    = pc_ff + 16'd1;
                  state_in = ST_OPER;
               end
               MODE_ZP, MODE_ABS: begin
                  ram_addr = pc_ff[ADDR_BITS-1:0];
                  pc_in    = pc_ff + 16'd1;
                  state_in = ST_OPLO;
               end
               default: begin
                  if (dec.kind == K_NONE) begin
                     emit = 1'b1;
                  end else begin
                     state_in = ST_OPER;
                  end
               end
            endcase
         end
         ST_OPLO: begin
            if (dec.mode == MODE_ZP) begin
               ea_in    = {8'h00, ram_rd};
               ram_addr = ADDR_BITS'({8'h00, ram_rd});
               state_in = ST_OPER;
            end else begin
               tmp_in   = ram_rd;
               ram_addr = pc_ff[ADDR_BITS-1:0];
               pc_in    = pc_ff + 16'd1;
               state_in = ST_OPHI;
            end
         end
         ST_OPHI: begin
            ea_in    = {ram_rd, tmp_ff};
            ram_addr = ADDR_BITS'({ram_rd, tmp_ff});
            state_in = (dec.kind == K_JMP) ? ST_JLO : ST_OPER;
         end
         ST_JLO: begin
            tmp_in   = ram_rd;
            ram_addr = ADDR_BITS'({ea_ff[15:8], ea_ff[7:0] + 8'd1});
            state_in = ST_JHI;
         end
         ST_JHI: begin
            pc_in      = {ram_rd, tmp_ff};
            emit       = 1'b1;
            emit_known = 1'b1;
         end
         ST_OPER: begin
            ram_addr   = ea_ff[ADDR_BITS-1:0];
            ram_wd     = wv;
            ram_we     = we_alu;
            acc_in     = a_o;
            x_in       = x_o;
            y_in       = y_o;
            st_in      = s_o;
            emit       = 1'b1;
            emit_known = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {emit_known && cmd_ff == CMD_EXEC,
                         (cmd_ff == CMD_EXEC) ? op_ff : 8'h00,
                         emit_rd, st_in, y_in, x_in, acc_in, pc_in};
      end
   end

endmodule

FILE: rtl/core/c6502_ram.sv
module c6502_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/c6502_alu.sv
module c6502_alu
   import c6502_pkg::*;
(
   input  kind_type   kind,
   input  logic       acc_mode,
   input  logic [7:0] v,
   input  logic [7:0] acc,
   input  logic [7:0] idx_x,
   input  logic [7:0] idx_y,
   input  logic [7:0] status,
   output logic [7:0] acc_out,
   output logic [7:0] x_out,
   output logic [7:0] y_out,
   output logic [7:0] status_out,
   output logic [7:0] wr_val,
   output logic       wr_en
);

   logic [8:0] sum;
   logic [7:0] m;
   logic [7:0] r;
   logic       nz;
   logic       c_in;

   always_comb begin
      acc_out    = acc;
      x_out      = idx_x;
      y_out      = idx_y;
      status_out = status;
      wr_val     = 8'h00;
      wr_en      = 1'b0;
      r          = 8'h00;
      nz         = 1'b0;
      c_in       = status[0];
      m          = (kind == K_SBC) ? ~v : v;
      sum        = {1'b0, acc} + {1'b0, m} + {8'h00, c_in};
      unique case (kind)
         K_LDA: begin r = v; acc_out = r; nz = 1'b1; end
         K_STA: begin wr_val = acc; wr_en = 1'b1; end
         K_ADC, K_SBC: begin
            r = sum[7:0];
            acc_out = r;
            nz = 1'b1;
            status_out[0] = sum[8];
            status_out[6] = ~(acc[7] ^ m[7]) & (acc[7] ^ sum[7]);
         end
         K_AND: begin r = acc & v; acc_out = r; nz = 1'b1; end
         K_ORA: begin r = acc | v; acc_out = r; nz = 1'b1; end
         K_EOR: begin r = acc ^ v; acc_out = r; nz = 1'b1; end
         K_BIT: begin
            status_out[1] = ((acc & v) == 8'h00);
            status_out[7] = v[7];
            status_out[6] = v[6];
         end
         K_INC: begin r = v + 8'd1; wr_val = r; wr_en = 1'b1; nz = 1'b1; end
         K_DEC: begin r = v - 8'd1; wr_val = r; wr_en = 1'b1; nz = 1'b1; end
         K_ASL, K_LSR, K_ROL, K_ROR: begin
            unique case (kind)
               K_ASL: begin r = {v[6:0], 1'b0}; status_out[0] = v[7]; end
               K_ROL: begin r = {v[6:0], c_in}; status_out[0] = v[7]; end
               K_LSR: begin r = {1'b0, v[7:1]}; status_out[0] = v[0]; end
               default: begin r = {c_in, v[7:1]}; status_out[0] = v[0]; end
            endcase
            nz = 1'b1;
            if (acc_mode) begin
               acc_out = r;
            end else begin
               wr_val = r;
               wr_en = 1'b1;
            end
         end
         K_INX: begin r = idx_x + 8'd1; x_out = r; nz = 1'b1; end
         K_INY: begin r = idx_y + 8'd1; y_out = r; nz = 1'b1; end
         K_DEX: begin r = idx_x - 8'd1; x_out = r; nz = 1'b1; end
         K_DEY: begin r = idx_y - 8'd1; y_out = r; nz = 1'b1; end
         default: begin end
      endcase
      if (nz) begin
         status_out[1] = (r == 8'h00);
         status_out[7] = r[7];
      end
   end

endmodule

FILE: rtl/core/c6502_checker.sv
module c6502_checker
   import c6502_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed under stall");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("command taken while result pending");

   a_flags_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[45:42] == 4'h0)
      else $error("unused status bits set");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_LOAD |=> ##1 rsp_tvalid
      && rsp_tdata[71:48] == 24'h0)
      else $error("load result malformed");

endmodule

bind cpu6502_subset_core_unit c6502_checker u_c6502_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import c6502_pkg::*;

   typedef struct packed {
      logic       known_op;
      logic [7:0] last_opcode;
      logic [7:0] read_byte;
      logic [7:0] flags;
      logic [7:0] index_y;
      logic [7:0] index_x;
      logic [7:0] acc;
      logic [15:0] prog_counter;
   } cpu_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = CMD_LOAD;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   cpu6502_subset_core_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   logic [7:0]  model_mem [0:65535];
   logic [15:0] model_pc = '0;
   logic [7:0]  model_a = '0;
   logic [7:0]  model_x = '0;
   logic [7:0]  model_y = '0;
   logic [7:0]  model_p = '0;
   cpu_view_type pending_views[$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          items_sent = 0;
   int          send_idle = 0;
   int          recv_idle = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
      mismatches++;
   endtask

   function automatic logic [7:0] rd(input logic [15:0] a);
      return model_mem[a];
   endfunction

   function automatic void put_nz(input logic [7:0] v);
      model_p[1] = (v == 8'h00);
      model_p[7] = v[7];
   endfunction

   function automatic void add_to_acc(input logic [7:0] m);
      logic [8:0] t;
      t = model_a + m + model_p[0];
      model_p[0] = t[8];
      model_p[6] = (~(model_a[7] ^ m[7])) & (model_a[7] ^ t[7]);
      model_a = t[7:0];
      put_nz(model_a);
   endfunction

   function automatic bit run_instruction(input logic [7:0] op);
      mode_type   md;
      kind_type   kd;
      logic [15:0] ea;
      logic [7:0]  v, r, c;
      md = MODE_ACC; kd = K_NONE; ea = '0;
      case (op)
         8'hA9: begin md = MODE_IMM; kd = K_LDA; end
         8'hA5: begin md = MODE_ZP;  kd = K_LDA; end
         8'hAD: begin md = MODE_ABS; kd = K_LDA; end
         8'h85: begin md = MODE_ZP;  kd = K_STA; end
         8'h8D: begin md = MODE_ABS; kd = K_STA; end
         8'h69: begin md = MODE_IMM; kd = K_ADC; end
         8'h65: begin md = MODE_ZP;  kd = K_ADC; end
         8'h6D: begin md = MODE_ABS; kd = K_ADC; end
         8'hE9: begin md = MODE_IMM; kd = K_SBC; end
         8'hE5: begin md = MODE_ZP;  kd = K_SBC; end
         8'hED: begin md = MODE_ABS; kd = K_SBC; end
         8'hE8: kd = K_INX;
         8'hC8: kd = K_INY;
         8'hCA: kd = K_DEX;
         8'h88: kd = K_DEY;
         8'hE6: begin md = MODE_ZP;  kd = K_INC; end
         8'hEE: begin md = MODE_ABS; kd = K_INC; end
         8'hC6: begin md = MODE_ZP;  kd = K_DEC; end
         8'hCE: begin md = MODE_ABS; kd = K_DEC; end
         8'h29: begin md = MODE_IMM; kd = K_AND; end
         8'h25: begin md = MODE_ZP;  kd = K_AND; end
         8'h2D: begin md = MODE_ABS; kd = K_AND; end
         8'h09: begin md = MODE_IMM; kd = K_ORA; end
         8'h05: begin md = MODE_ZP;  kd = K_ORA; end
         8'h0D: begin md = MODE_ABS; kd = K_ORA; end
         8'h49: begin md = MODE_IMM; kd = K_EOR; end
         8'h45: begin md = MODE_ZP;  kd = K_EOR; end
         8'h4D: begin md = MODE_ABS; kd = K_EOR; end
         8'h24: begin md = MODE_ZP;  kd = K_BIT; end
         8'h2C: begin md = MODE_ABS; kd = K_BIT; end
         8'h0A: kd = K_ASL;
         8'h06: begin md = MODE_ZP;  kd = K_ASL; end
         8'h0E: begin md = MODE_ABS; kd = K_ASL; end
         8'h4A: kd = K_LSR;
         8'h46: begin md = MODE_ZP;  kd = K_LSR; end
         8'h4E: begin md = MODE_ABS; kd = K_LSR; end
         8'h2A: kd = K_ROL;
         8'h26: begin md = MODE_ZP;  kd = K_ROL; end
         8'h2E: begin md = MODE_ABS; kd = K_ROL; end
         8'h6A: kd = K_ROR;
         8'h66: begin md = MODE_ZP;  kd = K_ROR; end
         8'h6E: begin md = MODE_ABS; kd = K_ROR; end
         8'h6C: begin md = MODE_ABS; kd = K_JMP; end
         default: kd = K_NONE;
      endcase
      if (kd == K_NONE) return 1'b0;
      if (md == MODE_IMM) begin
         ea = model_pc; model_pc++;
      end else if (md == MODE_ZP) begin
         ea = {8'h00, rd(model_pc)}; model_pc++;
      end else if (md == MODE_ABS) begin
         ea[7:0] = rd(model_pc); model_pc++;
         ea[15:8] = rd(model_pc); model_pc++;
      end
      case (kd)
         K_JMP: begin
            model_pc = {rd({ea[15:8], ea[7:0] + 8'd1}), rd(ea)};
            return 1'b1;
         end
         K_STA: begin model_mem[ea] = model_a; return 1'b1; end
         K_INX: begin model_x++; put_nz(model_x); return 1'b1; end
         K_INY: begin model_y++; put_nz(model_y); return 1'b1; end
         K_DEX: begin model_x--; put_nz(model_x); return 1'b1; end
         K_DEY: begin model_y--; put_nz(model_y); return 1'b1; end
         default: ;
      endcase
      v = (md == MODE_ACC) ? model_a : rd(ea);
      case (kd)
         K_LDA: begin model_a = v; put_nz(v); return 1'b1; end
         K_ADC: begin add_to_acc(v); return 1'b1; end
         K_SBC: begin add_to_acc(~v); return 1'b1; end
         K_AND: begin model_a &= v; put_nz(model_a); return 1'b1; end
         K_ORA: begin model_a |= v; put_nz(model_a); return 1'b1; end
         K_EOR: begin model_a ^= v; put_nz(model_a); return 1'b1; end
         K_BIT: begin
            model_p[1] = ((model_a & v) == 8'h00);
            model_p[7] = v[7];
            model_p[6] = v[6];
            return 1'b1;
         end
         K_INC: begin r = v + 8'd1; model_mem[ea] = r; put_nz(r); return 1'b1; end
         K_DEC: begin r = v - 8'd1; model_mem[ea] = r; put_nz(r); return 1'b1; end
         K_ASL: begin model_p[0] = v[7]; r = {v[6:0], 1'b0}; end
         K_LSR: begin model_p[0] = v[0]; r = {1'b0, v[7:1]}; end
         K_ROL: begin c = model_p[0]; model_p[0] = v[7]; r = {v[6:0], c[0]}; end
         default: begin c = model_p[0]; model_p[0] = v[0]; r = {c[0], v[7:1]}; end
      endcase
      put_nz(r);
      if (md == MODE_ACC) model_a = r;
      else model_mem[ea] = r;
      return 1'b1;
   endfunction

   function automatic cpu_view_type predict_command(input cmd_type cmd, input logic [15:0] a,
                                                    input logic [7:0] d);
      cpu_view_type e;
      e = '0;
      case (cmd)
         CMD_LOAD: model_mem[a] = d;
         CMD_READ: e.read_byte = model_mem[a];
         CMD_EXEC: begin
            e.last_opcode = rd(model_pc);
            model_pc++;
            e.known_op = run_instruction(e.last_opcode);
         end
         default: ;
      endcase
      e.prog_counter = model_pc;
      e.acc = model_a;
      e.index_x = model_x;
      e.index_y = model_y;
      e.flags = model_p;
      return e;
   endfunction

   task automatic send_command(input cmd_type cmd, input logic [15:0] a, input logic [7:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {d, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_views.push_back(predict_command(cmd, a, d));
      items_sent++;
   endtask

   always @(posedge clock) begin
      cpu_view_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got = cpu_view_type'(rsp_tdata[64:0]);
         if (pending_views.size() == 0) begin
            report("unexpected transfer", 0, 0);
         end else begin
            want = pending_views.pop_front();
            if (got.prog_counter !== want.prog_counter)
               report("prog_counter", got.prog_counter, want.prog_counter);
            if (got.acc !== want.acc) report("acc", got.acc, want.acc);
            if (got.index_x !== want.index_x) report("index_x", got.index_x, want.index_x);
            if (got.index_y !== want.index_y) report("index_y", got.index_y, want.index_y);
            if (got.flags !== want.flags) report("flags", got.flags, want.flags);
            if (got.read_byte !== want.read_byte)
               report("read_byte", got.read_byte, want.read_byte);
            if (got.last_opcode !== want.last_opcode)
               report("last_opcode", got.last_opcode, want.last_opcode);
            if (got.known_op !== want.known_op) report("known_op", got.known_op, want.known_op);
         end
         results_seen++;
      end
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic jump_to(input logic [15:0] target);
      logic [15:0] ptr;
      ptr = 16'h7F00 + model_pc[7:0];
      if (ptr[7:0] == 8'hFF) ptr = 16'h7E10;
      send_command(CMD_LOAD, model_pc, 8'h6C);
      send_command(CMD_LOAD, model_pc + 16'd1, ptr[7:0]);
      send_command(CMD_LOAD, model_pc + 16'd2, ptr[15:8]);
      send_command(CMD_LOAD, ptr, target[7:0]);
      send_command(CMD_LOAD, ptr + 16'd1, target[15:8]);
      send_command(CMD_EXEC, 0, 0);
   endtask

   task automatic test_directed;
      send_command(CMD_LOAD, 16'h0000, 8'hA9);
      send_command(CMD_LOAD, 16'h0001, 8'h80);
      send_command(CMD_EXEC, 16'hFFFF, 8'hFF);
      send_command(CMD_LOAD, 16'h0002, 8'h69);
      send_command(CMD_LOAD, 16'h0003, 8'h80);
      send_command(CMD_EXEC, 0, 0);
      send_command(CMD_LOAD, 16'h0004, 8'hE9);
      send_command(CMD_LOAD, 16'h0005, 8'h01);
      send_command(CMD_EXEC, 0, 0);
      send_command(CMD_LOAD, 16'h0006, 8'h02);
      send_command(CMD_EXEC, 0, 0);
      send_command(CMD_NOP, 16'hFFFF, 8'hFF);
      send_command(CMD_LOAD, 16'hFFFF, 8'hFF);
      send_command(CMD_READ, 16'hFFFF, 8'h00);
      // pointer low byte at page end: high byte from page start
      send_command(CMD_LOAD, 16'h0007, 8'h6C);
      send_command(CMD_LOAD, 16'h0008, 8'hFF);
      send_command(CMD_LOAD, 16'h0009, 8'h12);
      send_command(CMD_LOAD, 16'h12FF, 8'h40);
      send_command(CMD_LOAD, 16'h1200, 8'h30);
      send_command(CMD_LOAD, 16'h1300, 8'h99);
      send_command(CMD_EXEC, 0, 0);
      send_command(CMD_LOAD, 16'h3040, 8'h5A);
      send_command(CMD_READ, 16'h3040, 0);
   endtask

   task automatic random_instruction;
      logic [7:0] ops[$];
      logic [7:0] op;
      logic [15:0] base, ea;
      logic [7:0] zp;
      ops = '{8'hA9,8'hA5,8'hAD,8'h85,8'h8D,8'h69,8'h65,8'h6D,8'hE9,8'hE5,8'hED,8'hE8,
              8'hC8,8'hCA,8'h88,8'hE6,8'hEE,8'hC6,8'hCE,8'h29,8'h25,8'h2D,8'h09,8'h05,
              8'h0D,8'h49,8'h45,8'h4D,8'h24,8'h2C,8'h0A,8'h06,8'h0E,8'h4A,8'h46,8'h4E,
              8'h2A,8'h26,8'h2E,8'h6A,8'h66,8'h6E};
      base = model_pc;
      if (base < 16'h0200 || base > 16'hFF00) begin
         jump_to({8'($urandom_range(8'h02, 8'hFE)), 8'($urandom)});
         base = model_pc;
      end
      op = ($urandom_range(9) == 0) ? 8'h02 : ops[$urandom_range(ops.size() - 1)];
      zp = $urandom;
      ea = (op[3:0] inside {4'h5, 4'h6, 4'h4}) ? {8'h00, zp} : {8'($urandom_range(1)), zp};
      send_command(CMD_LOAD, base, op);
      send_command(CMD_LOAD, base + 16'd1, (op[3:0] == 4'h9) ? 8'($urandom) : ea[7:0]);
      send_command(CMD_LOAD, base + 16'd2, ea[15:8]);
      send_command(CMD_LOAD, ea, 8'($urandom));
      if ($urandom_range(3) == 0) send_command(CMD_READ, ea, 0);
      send_command(CMD_EXEC, 0, 0);
   endtask

   task automatic test_random(input int count);
      logic [15:0] a;
      repeat (count / 5) begin
         if ($urandom_range(9) == 0) begin
            a = $urandom;
            send_command(CMD_LOAD, a, 8'($urandom));
            send_command(CMD_READ, a, 0);
         end else begin
            random_instruction();
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 24; recv_idle = 72;
      test_directed();
      test_random(350);
      send_idle = 72; recv_idle = 24;
      test_random(350);
      send_idle = 0; recv_idle = 0;
      test_random(350);
      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d commands sent, %0d results checked, all opcodes and idle patterns",
               items_sent, results_seen);
      if (mismatches == 0 && pending_views.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
